// File: hdl/pidc_pkg.sv
// shared types, constants and helpers for the clamped trapezoid pid controller
package pidc_pkg;

	// field widths
	localparam int DATA_W  = 32;
	localparam int GAIN_W  = 24;
	localparam int US_W    = 24;
	localparam int SF_W    = 17;
	localparam int DLIM_W  = 31;
	localparam int INTEG_W = 48;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// divider: magnitude width of the dividend, divisor width
	localparam int DIV_NW  = 57;
	localparam int DIV_DW  = 24;
	localparam int DIV_CW  = $clog2(DIV_NW + 1);

	// gain product floored by 2^16
	localparam int TERM_W  = 41;
	localparam int SUM_W   = TERM_W + 2;

	// fixed point and time constants
	localparam int Q_SHIFT        = 16;
	localparam int Q_ONE          = 65536;
	localparam int US_PER_S       = 1000000;
	localparam int AREA_DIV       = 2 * US_PER_S;
	localparam int INTEGRAL_LIMIT = 30000;
	localparam logic signed [INTEG_W-1:0] INTEG_LIM_Q =
		INTEG_W'(INTEGRAL_LIMIT) <<< Q_SHIFT;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_TARGET      = 3'd0,
		REG_KP          = 3'd1,
		REG_KI          = 3'd2,
		REG_KD          = 3'd3,
		REG_START       = 3'd4,
		REG_DLIM        = 3'd5,
		REG_OUT_LOW     = 3'd6,
		REG_OUT_HIGH    = 3'd7
	} cfg_reg_t;

	// request to the shared multiplier
	typedef struct packed {
		logic                       en;
		logic signed [MUL_A_W-1:0]  a;
		logic signed [MUL_B_W-1:0]  b;
	} mul_req_t;

	// request to the shared divider
	typedef struct packed {
		logic                       start;
		logic signed [DIV_NW:0]     num;
		logic [DIV_DW-1:0]          den;
	} div_req_t;

	// saturate a floored gain product to 32 bits
	function automatic logic signed [DATA_W-1:0] sat_term(input logic signed [TERM_W-1:0] v);
		if ((&v[TERM_W-1:DATA_W-1]) || !(|v[TERM_W-1:DATA_W-1]))
			return v[DATA_W-1:0];
		else if (v[TERM_W-1])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

endpackage

// File: hdl/pidc_mul.sv
// shared signed multiplier with a registered product
module pidc_mul import pidc_pkg::*; (
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// product loads only when a pass is issued, otherwise it holds
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
		end
	end

	assign prod = prod_q;

endmodule

// File: hdl/pidc_div.sv
// shift-subtract divider, one quotient bit per cycle, truncates toward zero
module pidc_div import pidc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  div_req_t               req,
	output logic                   done,
	output logic signed [DIV_NW:0] quot
);

	logic [DIV_CW-1:0]  cnt_q;
	logic               done_q;
	logic               neg_q;
	logic [DIV_NW-1:0]  quo_q;
	logic [DIV_DW-1:0]  rem_q;
	logic [DIV_DW-1:0]  den_q;
	logic [DIV_DW:0]    shifted;
	logic [DIV_DW+1:0]  trial;
	logic [DIV_NW-1:0]  num_abs;

	// magnitude of the dividend
	assign num_abs = req.num[DIV_NW] ? DIV_NW'(-req.num) : DIV_NW'(req.num);

	// one restoring step
	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	// control: step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DIV_CW'(DIV_NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= num_abs;
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.num[DIV_NW];
		end else if (cnt_q != '0) begin
			if (!trial[DIV_DW+1]) begin
				rem_q <= trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// File: hdl/pid_controller_trapezoid_clamped_unit.sv
// top level: pid controller with trapezoid integral, clamps and output bounds
// One sample at a time. The first sample after reset skips the area, gate and
// slope steps and goes straight to the integral clamp. For every later sample,
// the time to its result and to the next acceptance is set by two 57-step passes
// through the shared shift-subtract divider (the trapezoid area over 2e6 and the
// slope over elapsed time), six passes through the shared multiplier and the
// sequencer steps around them. in_ready is high only while the sequencer is idle.
// A finished result waits in the output registers and the next sample may be
// accepted meanwhile. If that sample finishes while the result is still waiting,
// the sequencer holds until the receiver takes the result. All values are signed
// Q16.16, gains unsigned Q8.16. An elapsed time of zero counts as one microsecond.
module pid_controller_trapezoid_clamped_unit import pidc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [DATA_W-1:0]         cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [DATA_W-1:0]  feedback,
	input  logic [US_W-1:0]           elapsed_us,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DATA_W-1:0]  drive,
	output logic signed [DATA_W-1:0]  error_value,
	output logic signed [DATA_W-1:0]  p_term,
	output logic signed [DATA_W-1:0]  i_term,
	output logic signed [DATA_W-1:0]  d_term,
	output logic signed [DATA_W-1:0]  integral_now
);

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_ERR     = 14'b00000000000010,
		S_M_AREA  = 14'b00000000000100,
		S_M_GATE  = 14'b00000000001000,
		S_M_SLOPE = 14'b00000000010000,
		S_W_AREA  = 14'b00000000100000,
		S_D_SLOPE = 14'b00000001000000,
		S_W_SLOPE = 14'b00000010000000,
		S_CLAMP   = 14'b00000100000000,
		S_M_P     = 14'b00001000000000,
		S_M_I     = 14'b00010000000000,
		S_M_D     = 14'b00100000000000,
		S_SUM     = 14'b01000000000000,
		S_FIN     = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic signed [DATA_W-1:0]  target_q;
	logic [GAIN_W-1:0]         kp_q, ki_q, kd_q;
	logic [SF_W-1:0]           sf_q;
	logic [DLIM_W-1:0]         dlim_q;
	logic signed [DATA_W-1:0]  out_low_q, out_high_q;

	// controller state
	logic                      first_q;
	logic signed [DATA_W-1:0]  prev_err_q;
	logic signed [INTEG_W-1:0] integral_q;
	logic signed [DATA_W-1:0]  slope_q;

	// per-sample working registers
	logic signed [DATA_W-1:0]  fb_q;
	logic [US_W-1:0]           us_q;
	logic signed [DATA_W-1:0]  err_q;
	logic                      gate_ok_q;
	logic signed [TERM_W-1:0]  pfull_q, ifull_q, dfull_q;
	logic signed [SUM_W-1:0]   sum_q;

	// result registers
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  drive_q, error_q, p_q, i_q, d_q, integ_out_q;

	// shared units
	mul_req_t                  mul_req;
	logic signed [PROD_W-1:0]  prod;
	div_req_t                  div_req;
	logic                      div_done;
	logic signed [DIV_NW:0]    div_quot;

	// combinational helpers
	logic signed [DATA_W:0]    err_wide;
	logic signed [DATA_W-1:0]  err_sat;
	logic signed [PROD_W-1:0]  err_scaled;
	logic signed [DIV_NW:0]    dlim_ext;
	logic signed [SUM_W-1:0]   sum_hi, drive_clamped;
	logic                      in_acc, out_free;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// saturating error from the latched sample
	assign err_wide = (DATA_W+1)'(target_q) - (DATA_W+1)'(fb_q);
	always_comb begin
		if (err_wide[DATA_W] == err_wide[DATA_W-1])
			err_sat = err_wide[DATA_W-1:0];
		else if (err_wide[DATA_W])
			err_sat = {1'b1, {(DATA_W-1){1'b0}}};
		else
			err_sat = {1'b0, {(DATA_W-1){1'b1}}};
	end

	assign err_scaled = PROD_W'(err_q) <<< Q_SHIFT;
	assign dlim_ext   = $signed({{(DIV_NW+1-DLIM_W){1'b0}}, dlim_q});

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			sf_q       <= '0;
			dlim_q     <= '1;
			out_low_q  <= {1'b1, {(DATA_W-1){1'b0}}};
			out_high_q <= {1'b0, {(DATA_W-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TARGET:   target_q   <= cfg_data;
				REG_KP:       kp_q       <= cfg_data[GAIN_W-1:0];
				REG_KI:       ki_q       <= cfg_data[GAIN_W-1:0];
				REG_KD:       kd_q       <= cfg_data[GAIN_W-1:0];
				REG_START:    sf_q       <= cfg_data[SF_W-1:0];
				REG_DLIM:     dlim_q     <= cfg_data[DLIM_W-1:0];
				REG_OUT_LOW:  out_low_q  <= cfg_data;
				REG_OUT_HIGH: out_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// multiplier operand selection per sequencer step
	always_comb begin
		mul_req.en = 1'b0;
		mul_req.a  = '0;
		mul_req.b  = '0;
		unique case (state_q)
			S_M_AREA: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_W'(prev_err_q) + MUL_A_W'(err_q);
				mul_req.b  = $signed({1'b0, us_q});
			end
			S_M_GATE: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_W'(target_q);
				mul_req.b  = MUL_B_W'($signed(
					(SF_W+1)'(Q_ONE) - {1'b0, sf_q}));
			end
			S_M_SLOPE: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_W'(err_q) - MUL_A_W'(prev_err_q);
				mul_req.b  = MUL_B_W'(US_PER_S);
			end
			S_M_P: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_W'(err_q);
				mul_req.b  = $signed({1'b0, kp_q});
			end
			S_M_I: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_W'($signed(integral_q[DATA_W-1:0]));
				mul_req.b  = $signed({1'b0, ki_q});
			end
			S_M_D: begin
				mul_req.en = 1'b1;
				mul_req.a  = MUL_A_W'(slope_q);
				mul_req.b  = $signed({1'b0, kd_q});
			end
			default: ;
		endcase
	end

	// divider start: area over 2e6, then slope over elapsed time
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = prod[DIV_NW:0];
		div_req.den   = DIV_DW'(AREA_DIV);
		if (state_q == S_M_GATE) begin
			div_req.start = 1'b1;
		end else if (state_q == S_D_SLOPE) begin
			div_req.start = 1'b1;
			div_req.den   = us_q;
		end
	end

	pidc_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	pidc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_d = S_ERR;
			S_ERR:     state_d = first_q ? S_CLAMP : S_M_AREA;
			S_M_AREA:  state_d = S_M_GATE;
			S_M_GATE:  state_d = S_M_SLOPE;
			S_M_SLOPE: state_d = S_W_AREA;
			S_W_AREA:  if (div_done) state_d = S_D_SLOPE;
			S_D_SLOPE: state_d = S_W_SLOPE;
			S_W_SLOPE: if (div_done) state_d = S_CLAMP;
			S_CLAMP:   state_d = S_M_P;
			S_M_P:     state_d = S_M_I;
			S_M_I:     state_d = S_M_D;
			S_M_D:     state_d = S_SUM;
			S_SUM:     state_d = S_FIN;
			S_FIN:     if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			first_q     <= 1'b1;
			prev_err_q  <= '0;
			integral_q  <= '0;
			slope_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// integrate the area when the gate allows it
			if (state_q == S_W_AREA && div_done && gate_ok_q) begin
				integral_q <= integral_q + div_quot[INTEG_W-1:0];
			end
			// clamped slope
			if (state_q == S_W_SLOPE && div_done) begin
				if (div_quot > dlim_ext)
					slope_q <= dlim_ext[DATA_W-1:0];
				else if (div_quot < -dlim_ext)
					slope_q <= DATA_W'(-dlim_ext);
				else
					slope_q <= div_quot[DATA_W-1:0];
			end
			// symmetric integral clamp
			if (state_q == S_CLAMP) begin
				if (integral_q > INTEG_LIM_Q)
					integral_q <= INTEG_LIM_Q;
				else if (integral_q < -INTEG_LIM_Q)
					integral_q <= -INTEG_LIM_Q;
			end
			// commit the sample, or retire a taken result
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
				first_q     <= 1'b0;
				prev_err_q  <= err_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output bounds: upper first, then lower
	assign sum_hi = (sum_q > SUM_W'(out_high_q)) ? SUM_W'(out_high_q) : sum_q;
	assign drive_clamped = (sum_hi < SUM_W'(out_low_q)) ? SUM_W'(out_low_q) : sum_hi;

	// working and result datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			fb_q <= feedback;
			us_q <= (elapsed_us == '0) ? US_W'(1) : elapsed_us;
		end
		if (state_q == S_ERR) begin
			err_q <= err_sat;
		end
		if (state_q == S_M_SLOPE) begin
			gate_ok_q <= err_scaled < prod;
		end
		if (state_q == S_M_I) begin
			pfull_q <= prod[TERM_W+Q_SHIFT-1:Q_SHIFT];
		end
		if (state_q == S_M_D) begin
			ifull_q <= prod[TERM_W+Q_SHIFT-1:Q_SHIFT];
		end
		if (state_q == S_SUM) begin
			dfull_q <= prod[TERM_W+Q_SHIFT-1:Q_SHIFT];
			sum_q   <= SUM_W'(pfull_q) + SUM_W'(ifull_q)
				+ SUM_W'($signed(prod[TERM_W+Q_SHIFT-1:Q_SHIFT]));
		end
		if (state_q == S_FIN && out_free) begin
			drive_q     <= drive_clamped[DATA_W-1:0];
			error_q     <= err_q;
			p_q         <= sat_term(pfull_q);
			i_q         <= sat_term(ifull_q);
			d_q         <= sat_term(dfull_q);
			integ_out_q <= integral_q[DATA_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign drive        = drive_q;
	assign error_value  = error_q;
	assign p_term       = p_q;
	assign i_term       = i_q;
	assign d_term       = d_q;
	assign integral_now = integ_out_q;

	// one sample in flight: no new transaction right after acceptance
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while a sample is in progress");

	// divider completes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_W_AREA || state_q == S_W_SLOPE))
		else $error("divider completion outside a wait step");

	// integral is within its limit once clamped
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_M_P) |-> (integral_q <= INTEG_LIM_Q && integral_q >= -INTEG_LIM_Q))
		else $error("integral outside its limit after clamping");

endmodule
